@@ rtl/core/stp_pkg.sv @@
`timescale 1ns / 1ps

package stp_pkg;

  // Field widths
  localparam int unsigned PosW     = 10;
  localparam int unsigned DimW     = 11;
  localparam int unsigned ColW     = 16;
  localparam int unsigned ProgW    = 9;
  localparam int unsigned MixW     = 8;
  localparam int unsigned ModeW    = 3;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 11;

  // Q8 progress: shift after a multiply, and the value for "complete"
  localparam int unsigned QShift   = 8;
  localparam logic [ProgW-1:0] ProgFull = 9'd256;

  // Transition modes
  typedef enum logic [ModeW-1:0] {
    MODE_FADE  = 3'd0,
    MODE_COVER = 3'd1,
    MODE_LEFT  = 3'd2,
    MODE_RIGHT = 3'd3,
    MODE_UP    = 3'd4,
    MODE_DOWN  = 3'd5,
    MODE_NONE  = 3'd6
  } mode_e;

  // Pixel source codes
  typedef enum logic [1:0] {
    SRC_OLD   = 2'd0,
    SRC_NEW   = 2'd1,
    SRC_BLEND = 2'd2,
    SRC_KEEP  = 2'd3
  } src_e;

  // Register indexes
  localparam logic [CfgIdxW-1:0] REG_MODE     = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_WIDTH    = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_HEIGHT   = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_PROGRESS = 2'd3;

  localparam logic [DimW-1:0] ResetDim = 11'd240;

  // Settings as seen by the mapping logic (dims clamped, offsets precomputed)
  typedef struct packed {
    logic [ModeW-1:0] mode;
    logic [DimW-1:0]  width;
    logic [DimW-1:0]  height;
    logic [DimW-1:0]  off_x;
    logic [DimW-1:0]  off_y;
    logic [MixW-1:0]  mix;
  } cfg_t;

  // One input item
  typedef struct packed {
    logic [PosW-1:0] pos_x;
    logic [PosW-1:0] pos_y;
    logic [ColW-1:0] color_old;
    logic [ColW-1:0] color_new;
  } item_t;

  // One result item
  typedef struct packed {
    src_e            source;
    logic [PosW-1:0] src_x;
    logic [PosW-1:0] src_y;
    logic [ColW-1:0] blended;
  } res_t;

  // Exact v / 255 for v below 65280
  function automatic logic [MixW-1:0] div255(input logic [15:0] v);
    logic [16:0] s;
    s = 17'(v) + 17'd1 + 17'(v >> 8);
    return s[15:8];
  endfunction

endpackage

@@ rtl/core/stp_cfg.sv @@
`timescale 1ns / 1ps

module stp_cfg #(
  parameter int unsigned MAX_DIM = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [stp_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [stp_pkg::CfgDataW-1:0]  cfg_wdata_i,
  output stp_pkg::cfg_t                 cfg_o
);
  import stp_pkg::*;

  localparam int unsigned ProdW = ProgW + DimW;
  localparam int unsigned MixProdW = ProgW + MixW;

  logic [ModeW-1:0] mode_q;
  logic [DimW-1:0]  width_q, height_q;
  logic [ProgW-1:0] prog_q;

  logic [DimW-1:0]  w_clamp, h_clamp;
  logic [ProgW-1:0] p_clamp;
  logic [ProdW-1:0] prod_x, prod_y;
  logic [ProdW-QShift-1:0] raw_x, raw_y;
  logic [MixProdW-1:0] mix_prod;
  logic [DimW-1:0]  off_x_d, off_x_q, off_y_d, off_y_q;
  logic [MixW-1:0]  mix_d, mix_q;

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_NONE;
      width_q  <= ResetDim;
      height_q <= ResetDim;
      prog_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MODE:     mode_q   <= cfg_wdata_i[ModeW-1:0];
        REG_WIDTH:    width_q  <= cfg_wdata_i[DimW-1:0];
        REG_HEIGHT:   height_q <= cfg_wdata_i[DimW-1:0];
        REG_PROGRESS: prog_q   <= cfg_wdata_i[ProgW-1:0];
        default: ;
      endcase
    end
  end

  // Clamp dims and progress
  assign w_clamp = (32'(width_q) > MAX_DIM) ? DimW'(MAX_DIM) : width_q;
  assign h_clamp = (32'(height_q) > MAX_DIM) ? DimW'(MAX_DIM) : height_q;
  assign p_clamp = (prog_q > ProgFull) ? ProgFull : prog_q;

  // Offsets (progress * size) >> 8, clamped to size
  assign prod_x = ProdW'(p_clamp) * ProdW'(w_clamp);
  assign prod_y = ProdW'(p_clamp) * ProdW'(h_clamp);
  assign raw_x  = prod_x[ProdW-1:QShift];
  assign raw_y  = prod_y[ProdW-1:QShift];
  assign off_x_d = (raw_x > (ProdW-QShift)'(w_clamp)) ? w_clamp : raw_x[DimW-1:0];
  assign off_y_d = (raw_y > (ProdW-QShift)'(h_clamp)) ? h_clamp : raw_y[DimW-1:0];

  // Fade weight (progress * 255) >> 8
  assign mix_prod = MixProdW'(p_clamp) * MixProdW'(255);
  assign mix_d    = mix_prod[QShift +: MixW];

  // Derived values are registered so the mapping path holds no multiply chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_x_q <= '0;
      off_y_q <= '0;
      mix_q   <= '0;
    end else begin
      off_x_q <= off_x_d;
      off_y_q <= off_y_d;
      mix_q   <= mix_d;
    end
  end

  assign cfg_o.mode   = mode_q;
  assign cfg_o.width  = w_clamp;
  assign cfg_o.height = h_clamp;
  assign cfg_o.off_x  = off_x_q;
  assign cfg_o.off_y  = off_y_q;
  assign cfg_o.mix    = mix_q;

endmodule

@@ rtl/core/stp_blend.sv @@
`timescale 1ns / 1ps

module stp_blend (
  input  logic [stp_pkg::ColW-1:0] color_old_i,
  input  logic [stp_pkg::ColW-1:0] color_new_i,
  input  logic [stp_pkg::MixW-1:0] mix_i,
  output logic [stp_pkg::ColW-1:0] blended_o
);
  import stp_pkg::*;

  // a*(255-m) + b*m fits in 14 bits for a 6-bit channel
  localparam int unsigned SumW = 14;

  logic [MixW-1:0] inv;
  logic [SumW-1:0] sum_r, sum_g, sum_b;
  logic [MixW-1:0] q_r, q_g, q_b;

  assign inv = 8'd255 - mix_i;

  // Per-channel weighted sums
  assign sum_r = SumW'(color_old_i[15:11]) * SumW'(inv) + SumW'(color_new_i[15:11]) * SumW'(mix_i);
  assign sum_g = SumW'(color_old_i[10:5])  * SumW'(inv) + SumW'(color_new_i[10:5])  * SumW'(mix_i);
  assign sum_b = SumW'(color_old_i[4:0])   * SumW'(inv) + SumW'(color_new_i[4:0])   * SumW'(mix_i);

  // Divide by 255, truncating
  assign q_r = div255(16'(sum_r));
  assign q_g = div255(16'(sum_g));
  assign q_b = div255(16'(sum_b));

  assign blended_o = {q_r[4:0], q_g[5:0], q_b[4:0]};

endmodule

@@ rtl/core/stp_map.sv @@
`timescale 1ns / 1ps

module stp_map (
  input  stp_pkg::item_t item_i,
  input  stp_pkg::cfg_t  cfg_i,
  output stp_pkg::res_t  res_o
);
  import stp_pkg::*;

  logic [DimW-1:0] x, y, rem_x, rem_y;
  logic [ColW-1:0] blend_w;

  assign x = DimW'(item_i.pos_x);
  assign y = DimW'(item_i.pos_y);

  // Part of the frame still held by the old image
  assign rem_x = cfg_i.width - cfg_i.off_x;
  assign rem_y = cfg_i.height - cfg_i.off_y;

  stp_blend u_blend (
    .color_old_i (item_i.color_old),
    .color_new_i (item_i.color_new),
    .mix_i       (cfg_i.mix),
    .blended_o   (blend_w)
  );

  // Source selection per mode; outside the frame the pixel is kept
  always_comb begin
    res_o.source  = SRC_KEEP;
    res_o.src_x   = item_i.pos_x;
    res_o.src_y   = item_i.pos_y;
    res_o.blended = '0;
    if (x < cfg_i.width && y < cfg_i.height) begin
      case (cfg_i.mode)
        MODE_FADE: begin
          res_o.source  = SRC_BLEND;
          res_o.blended = blend_w;
        end
        MODE_COVER: begin
          if (x >= rem_x) begin
            res_o.source = SRC_NEW;
            res_o.src_x  = PosW'(x - rem_x);
          end else begin
            res_o.source = SRC_OLD;
          end
        end
        MODE_LEFT: begin
          if (x < rem_x) begin
            res_o.source = SRC_OLD;
            res_o.src_x  = PosW'(x + cfg_i.off_x);
          end else begin
            res_o.source = SRC_NEW;
            res_o.src_x  = PosW'(x - rem_x);
          end
        end
        MODE_RIGHT: begin
          if (x < cfg_i.off_x) begin
            res_o.source = SRC_NEW;
            res_o.src_x  = PosW'(x + rem_x);
          end else begin
            res_o.source = SRC_OLD;
            res_o.src_x  = PosW'(x - cfg_i.off_x);
          end
        end
        MODE_UP: begin
          if (y < rem_y) begin
            res_o.source = SRC_OLD;
            res_o.src_y  = PosW'(y + cfg_i.off_y);
          end else begin
            res_o.source = SRC_NEW;
            res_o.src_y  = PosW'(y - rem_y);
          end
        end
        MODE_DOWN: begin
          if (y < cfg_i.off_y) begin
            res_o.source = SRC_NEW;
            res_o.src_y  = PosW'(y + rem_y);
          end else begin
            res_o.source = SRC_OLD;
            res_o.src_y  = PosW'(y - cfg_i.off_y);
          end
        end
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/core/screen_transition_pixel_mapper.sv @@
`timescale 1ns / 1ps
// done_o and the result come from the result register, which follows the input register.
// Throughput: one item per clock; busy is always low, so start is taken every cycle.
// Rate is set by the input register -> mapping/blend logic -> result register path.
// Reset: mode none, width and height 240, progress 0; no item in flight.
// The receiver cannot stall: each result holds for exactly one cycle.

module screen_transition_pixel_mapper #(
  parameter int unsigned MAX_DIM = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [stp_pkg::PosW-1:0]      pos_x_i,
  input  logic [stp_pkg::PosW-1:0]      pos_y_i,
  input  logic [stp_pkg::ColW-1:0]      color_old_i,
  input  logic [stp_pkg::ColW-1:0]      color_new_i,
  output logic                          done_o,
  output logic [1:0]                    source_o,
  output logic [stp_pkg::PosW-1:0]      src_x_o,
  output logic [stp_pkg::PosW-1:0]      src_y_o,
  output logic [stp_pkg::ColW-1:0]      blended_o,
  input  logic                          cfg_we_i,
  input  logic [stp_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [stp_pkg::CfgDataW-1:0]  cfg_wdata_i
);
  import stp_pkg::*;

  logic  accept;
  logic  in_vld_q, done_q;
  item_t item_q;
  res_t  res_d, res_q;
  cfg_t  cfg;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  stp_cfg #(
    .MAX_DIM (MAX_DIM)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= '{pos_x: pos_x_i, pos_y: pos_y_i,
                  color_old: color_old_i, color_new: color_new_i};
    end
  end

  stp_map u_map (
    .item_i (item_q),
    .cfg_i  (cfg),
    .res_o  (res_d)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_vld_q) begin
      res_q <= res_d;
    end
  end

  assign done_o    = done_q;
  assign source_o  = res_q.source;
  assign src_x_o   = res_q.src_x;
  assign src_y_o   = res_q.src_y;
  assign blended_o = res_q.blended;

  // Every result traces back to an accepted item, through the input and result registers
  a_done_from_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, 2))
    else $error("result without accepted item");

  // Blend value only when blending
  a_blend_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && source_o != SRC_BLEND) |-> (blended_o == '0))
    else $error("blended nonzero for non-blend source");

  // Kept and blended pixels report their own position
  a_keep_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (source_o == SRC_KEEP || source_o == SRC_BLEND))
      |-> (src_x_o == $past(pos_x_i, 2) && src_y_o == $past(pos_y_i, 2)))
    else $error("position changed for kept or blended pixel");

  // Only fade mode produces blended pixels
  a_blend_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && cfg.mode != MODE_FADE) |-> (source_o != SRC_BLEND))
    else $error("blend outside fade mode");

endmodule

@@ tb/stp_map_checker.sv @@
`timescale 1ns / 1ps

// Watches the item and result channels of the pixel mapper, keeps its own
// copy of the settings, predicts every result and compares it in order.
module stp_map_checker
  import stp_pkg::*;
#(
  parameter int unsigned MAX_DIM = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic                busy_i,
  input  logic [PosW-1:0]     pos_x_i,
  input  logic [PosW-1:0]     pos_y_i,
  input  logic [ColW-1:0]     color_old_i,
  input  logic [ColW-1:0]     color_new_i,
  input  logic                done_i,
  input  logic [1:0]          source_i,
  input  logic [PosW-1:0]     src_x_i,
  input  logic [PosW-1:0]     src_y_i,
  input  logic [ColW-1:0]     blended_i,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output int                  err_cnt_o,
  output int                  pend_cnt_o
);

  // Shadow copy of the settings registers
  logic [ModeW-1:0] mode_q;
  logic [DimW-1:0]  width_q;
  logic [DimW-1:0]  height_q;
  logic [ProgW-1:0] prog_q;

  res_t px_exp_q[$];
  res_t want;
  int   err_cnt = 0;
  int   pend_cnt = 0;

  assign err_cnt_o  = err_cnt;
  assign pend_cnt_o = pend_cnt;

  // Slide offset: (progress * size) >> 8, never past the size
  function automatic int unsigned slide_offset(input int unsigned p, input int unsigned size);
    int unsigned o;
    o = (p * size) >> QShift;
    return (o > size) ? size : o;
  endfunction

  // Linear mix of one color channel, truncating divide
  function automatic int unsigned mix_ch(input int unsigned a, input int unsigned b,
                                         input int unsigned m);
    return (a * (255 - m) + b * m) / 255;
  endfunction

  // Expected result for one pixel under the current settings
  function automatic res_t map_pixel(input logic [PosW-1:0] x, input logic [PosW-1:0] y,
                                     input logic [ColW-1:0] co, input logic [ColW-1:0] cn);
    int unsigned w, h, p, o, m;
    res_t r;
    w = (width_q > MAX_DIM) ? MAX_DIM : width_q;
    h = (height_q > MAX_DIM) ? MAX_DIM : height_q;
    p = (prog_q > ProgFull) ? ProgFull : prog_q;
    r.source  = SRC_KEEP;
    r.src_x   = x;
    r.src_y   = y;
    r.blended = '0;
    if (x < w && y < h) begin
      case (mode_q)
        MODE_FADE: begin
          m = (p * 255) >> QShift;
          r.source  = SRC_BLEND;
          r.blended = {5'(mix_ch(co[15:11], cn[15:11], m)),
                       6'(mix_ch(co[10:5], cn[10:5], m)),
                       5'(mix_ch(co[4:0], cn[4:0], m))};
        end
        MODE_COVER: begin
          o = slide_offset(p, w);
          if (x >= w - o) begin
            r.source = SRC_NEW;
            r.src_x  = PosW'(x - (w - o));
          end else begin
            r.source = SRC_OLD;
          end
        end
        MODE_LEFT: begin
          o = slide_offset(p, w);
          if (x < w - o) begin
            r.source = SRC_OLD;
            r.src_x  = PosW'(x + o);
          end else begin
            r.source = SRC_NEW;
            r.src_x  = PosW'(x - (w - o));
          end
        end
        MODE_RIGHT: begin
          o = slide_offset(p, w);
          if (x < o) begin
            r.source = SRC_NEW;
            r.src_x  = PosW'(x + (w - o));
          end else begin
            r.source = SRC_OLD;
            r.src_x  = PosW'(x - o);
          end
        end
        MODE_UP: begin
          o = slide_offset(p, h);
          if (y < h - o) begin
            r.source = SRC_OLD;
            r.src_y  = PosW'(y + o);
          end else begin
            r.source = SRC_NEW;
            r.src_y  = PosW'(y - (h - o));
          end
        end
        MODE_DOWN: begin
          o = slide_offset(p, h);
          if (y < o) begin
            r.source = SRC_NEW;
            r.src_y  = PosW'(y + (h - o));
          end else begin
            r.source = SRC_OLD;
            r.src_y  = PosW'(y - o);
          end
        end
        default: ;
      endcase
    end
    return r;
  endfunction

  // Track settings, check results against the oldest prediction, queue new ones
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   = MODE_NONE;
      width_q  = ResetDim;
      height_q = ResetDim;
      prog_q   = '0;
      px_exp_q.delete();
      pend_cnt = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_MODE:     mode_q   = cfg_wdata_i[ModeW-1:0];
          REG_WIDTH:    width_q  = cfg_wdata_i;
          REG_HEIGHT:   height_q = cfg_wdata_i;
          REG_PROGRESS: prog_q   = cfg_wdata_i[ProgW-1:0];
          default: ;
        endcase
      end
      if (done_i) begin
        if (px_exp_q.size() == 0) begin
          if (err_cnt < 10)
            $display("%0t: result with no item pending: src=%0d x=%0d y=%0d blend=%h",
                     $realtime, source_i, src_x_i, src_y_i, blended_i);
          err_cnt++;
        end else begin
          want = px_exp_q.pop_front();
          if (source_i !== want.source || src_x_i !== want.src_x ||
              src_y_i !== want.src_y || blended_i !== want.blended) begin
            if (err_cnt < 10)
              $display("%0t: mismatch exp src=%0d x=%0d y=%0d blend=%h got src=%0d x=%0d y=%0d blend=%h",
                       $realtime, want.source, want.src_x, want.src_y, want.blended,
                       source_i, src_x_i, src_y_i, blended_i);
            err_cnt++;
          end
        end
      end
      if (start_i && !busy_i)
        px_exp_q.push_back(map_pixel(pos_x_i, pos_y_i, color_old_i, color_new_i));
      pend_cnt = px_exp_q.size();
    end
  end

endmodule

@@ tb/tb_screen_transition_pixel_mapper.sv @@
`timescale 1ns / 1ps

module tb_screen_transition_pixel_mapper;
  import stp_pkg::*;

  localparam int unsigned MaxDim     = 1024;
  localparam int          NumRandPx  = 950;
  localparam int          DrainPad   = 4;
  localparam int          WdLimit    = 2000;
  localparam logic [ModeW-1:0] ModeUnused = 3'd7;

  logic                clk_i;
  logic                rst_ni;
  logic                start;
  logic                busy;
  logic [PosW-1:0]     pos_x;
  logic [PosW-1:0]     pos_y;
  logic [ColW-1:0]     color_old;
  logic [ColW-1:0]     color_new;
  logic                done;
  logic [1:0]          source;
  logic [PosW-1:0]     src_x;
  logic [PosW-1:0]     src_y;
  logic [ColW-1:0]     blended;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_wdata;
  int                  err_cnt;
  int                  pend_cnt;

  // Current frame size as programmed, used to aim positions inside the frame
  int unsigned cur_w = ResetDim;
  int unsigned cur_h = ResetDim;
  bit          no_gap;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  screen_transition_pixel_mapper #(
    .MAX_DIM(MaxDim)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .pos_x_i     (pos_x),
    .pos_y_i     (pos_y),
    .color_old_i (color_old),
    .color_new_i (color_new),
    .done_o      (done),
    .source_o    (source),
    .src_x_o     (src_x),
    .src_y_o     (src_y),
    .blended_o   (blended),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  stp_map_checker #(
    .MAX_DIM(MaxDim)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .busy_i      (busy),
    .pos_x_i     (pos_x),
    .pos_y_i     (pos_y),
    .color_old_i (color_old),
    .color_new_i (color_new),
    .done_i      (done),
    .source_i    (source),
    .src_x_i     (src_x),
    .src_y_i     (src_y),
    .blended_i   (blended),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .err_cnt_o   (err_cnt),
    .pend_cnt_o  (pend_cnt)
  );

  // Idle cycles after an item: mostly none or short, a few long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_gap || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Frame size pick: extremes, clamped and empty sizes mixed in
  function automatic int unsigned rand_dim();
    int unsigned d;
    case ($urandom_range(0, 9))
      0:       d = 1;
      1:       d = MaxDim;
      2:       d = $urandom_range(MaxDim + 1, 2047);
      3:       d = 0;
      default: d = $urandom_range(1, MaxDim);
    endcase
    return d;
  endfunction

  // Present one item and hold it until taken
  task automatic send_px(input logic [PosW-1:0] x, input logic [PosW-1:0] y,
                         input logic [ColW-1:0] co, input logic [ColW-1:0] cn);
    int n;
    start     <= 1'b1;
    pos_x     <= x;
    pos_y     <= y;
    color_old <= co;
    color_new <= cn;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    n = gap_len();
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // Random pixel, mostly inside the active frame
  task automatic send_rand_px();
    int unsigned wx, hy;
    logic [PosW-1:0] x, y;
    wx = (cur_w > MaxDim) ? MaxDim : cur_w;
    hy = (cur_h > MaxDim) ? MaxDim : cur_h;
    x  = PosW'($urandom);
    y  = PosW'($urandom);
    if ($urandom_range(0, 9) < 8 && wx > 0 && hy > 0) begin
      x = PosW'($urandom_range(0, wx - 1));
      y = PosW'($urandom_range(0, hy - 1));
    end
    send_px(x, y, ColW'($urandom), ColW'($urandom));
  endtask

  // Wait until every predicted result has come back, plus a short pad
  task automatic drain();
    do @(negedge clk_i); while (pend_cnt != 0);
    @(posedge clk_i);
    repeat (DrainPad) @(posedge clk_i);
  endtask

  // Program all four settings while the block is idle
  task automatic set_cfg(input logic [ModeW-1:0] m, input int unsigned w,
                         input int unsigned h, input int unsigned p);
    start <= 1'b0;
    drain();
    cfg_we    <= 1'b1;
    cfg_idx   <= REG_MODE;
    cfg_wdata <= {8'($urandom), m};
    @(posedge clk_i);
    cfg_idx   <= REG_WIDTH;
    cfg_wdata <= CfgDataW'(w);
    @(posedge clk_i);
    cfg_idx   <= REG_HEIGHT;
    cfg_wdata <= CfgDataW'(h);
    @(posedge clk_i);
    cfg_idx   <= REG_PROGRESS;
    cfg_wdata <= {2'($urandom), ProgW'(p)};
    @(posedge clk_i);
    cfg_we <= 1'b0;
    cur_w = w;
    cur_h = h;
  endtask

  // Stall watchdog: nothing accepted for too long ends the run
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < WdLimit) begin
      @(posedge clk_i);
      if (!rst_ni || (start && !busy) || done || cfg_we) idle = 0;
      else idle++;
    end
    $display("tb_screen_transition_pixel_mapper: FAIL");
    $finish;
  end

  // Stimulus and verdict
  initial begin
    int sent, n, r;
    logic [ModeW-1:0] m;
    int unsigned w, h, p;

    rst_ni    = 1'b0;
    start     = 1'b0;
    pos_x     = '0;
    pos_y     = '0;
    color_old = '0;
    color_new = '0;
    cfg_we    = 1'b0;
    cfg_idx   = REG_MODE;
    cfg_wdata = '0;
    no_gap    = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: mode none, edge of the 240x240 frame
    send_px(10'd0, 10'd0, 16'h0000, 16'h0000);
    send_px(10'd239, 10'd239, 16'hFFFF, 16'hFFFF);
    send_px(10'd240, 10'd0, 16'hFFFF, 16'h0000);
    send_px(10'd1023, 10'd1023, 16'hAAAA, 16'h5555);

    // Fade at start, end and midway
    set_cfg(MODE_FADE, 240, 240, 0);
    send_px(10'd5, 10'd5, 16'hFFFF, 16'h0000);
    set_cfg(MODE_FADE, 240, 240, 256);
    send_px(10'd5, 10'd5, 16'hFFFF, 16'h0000);
    send_px(10'd5, 10'd5, 16'h0000, 16'hFFFF);
    set_cfg(MODE_FADE, 240, 240, 128);
    send_px(10'd1, 10'd2, 16'hF81F, 16'h07E0);

    // Cover, full frame, complete
    set_cfg(MODE_COVER, MaxDim, MaxDim, 256);
    send_px(10'd0, 10'd0, 16'h1234, 16'h4321);
    send_px(10'd1023, 10'd1023, 16'h1234, 16'h4321);

    // Push left at half
    set_cfg(MODE_LEFT, MaxDim, MaxDim, 128);
    send_px(10'd0, 10'd300, 16'h0F0F, 16'hF0F0);
    send_px(10'd1023, 10'd300, 16'h0F0F, 16'hF0F0);

    // Slide right, progress past complete
    set_cfg(MODE_RIGHT, 7, 7, 511);
    send_px(10'd0, 10'd3, 16'h0001, 16'h8000);
    send_px(10'd6, 10'd6, 16'h0001, 16'h8000);

    // Slide up, height past the maximum
    set_cfg(MODE_UP, 20, 2047, 1);
    send_px(10'd5, 10'd0, 16'h7FFF, 16'h8000);
    send_px(10'd5, 10'd1023, 16'h7FFF, 16'h8000);

    // Slide down, width past the maximum, one-row frame
    set_cfg(MODE_DOWN, 2047, 1, 255);
    send_px(10'd0, 10'd0, 16'hFFFF, 16'h0001);
    send_px(10'd0, 10'd1, 16'hFFFF, 16'h0001);

    // Unused mode code
    set_cfg(ModeUnused, 240, 240, 100);
    send_px(10'd3, 10'd3, 16'h1111, 16'h2222);

    // Empty frames
    set_cfg(MODE_COVER, 0, 240, 200);
    send_px(10'd0, 10'd0, 16'h3333, 16'h4444);
    set_cfg(MODE_FADE, 240, 0, 200);
    send_px(10'd0, 10'd0, 16'h3333, 16'h4444);

    // Random phases, each with fresh settings
    sent = 0;
    while (sent < NumRandPx) begin
      r = $urandom_range(0, 99);
      if (r < 5) m = MODE_NONE;
      else if (r < 8) m = ModeUnused;
      else m = ModeW'($urandom_range(MODE_FADE, MODE_DOWN));
      w = rand_dim();
      h = rand_dim();
      case ($urandom_range(0, 7))
        0:       p = 0;
        1:       p = 256;
        2:       p = $urandom_range(257, 511);
        default: p = $urandom_range(0, 256);
      endcase
      set_cfg(m, w, h, p);
      no_gap = ($urandom_range(0, 3) == 0);
      n = $urandom_range(20, 60);
      repeat (n) send_rand_px();
      sent += n;
    end

    start <= 1'b0;
    drain();
    repeat (8) @(posedge clk_i);
    if (err_cnt == 0 && pend_cnt == 0) begin
      $display("tb_screen_transition_pixel_mapper: PASS");
    end else begin
      $display("tb_screen_transition_pixel_mapper: FAIL");
    end
    $finish;
  end

endmodule
